### rtl/tsf_pkg.sv
// shared types and constants for the tagged slot fill and free unit
// word layouts for both channels, request and status codes, default sizes
// no dependencies
package tsf_pkg;

  localparam int TAG_W = 16;
  localparam int CNT_W = 5;

  localparam int DEF_ROWS     = 4;
  localparam int DEF_COLS     = 4;
  localparam int DEF_TAG_BITS = 16;

  localparam logic ACT_FILL = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } tsf_in_t;

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] free_slots;
    logic [CNT_W-1:0] slots_changed;
  } tsf_out_t;

endpackage

### rtl/tsf_slot_mem.sv
// slot store: one write port, one read port with registered read data
// per-entry valid bits make unwritten entries read as empty after reset
// no package dependencies
module tsf_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_q_r;
  logic             rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_addr];
      end
    end
  end

  // entry never written since reset reads as empty
  assign rd_data = rd_hit_r ? rd_q_r : '0;

endmodule

### rtl/tagged_slot_fill_and_free_unit.sv
// tagged slot fill and free unit: top level
// a scanned request passes through the scan, drain and done states before its
//   result word is registered; a fill rejected for lack of space goes straight to done
// a new request is taken only in idle, after the last result word is loaded; the single
//   read port of the slot store visits one slot per cycle
// reset: synchronous, clears all slots to empty and the free count to ROWS*COLS
module tagged_slot_fill_and_free_unit #(
  parameter int ROWS     = tsf_pkg::DEF_ROWS,
  parameter int COLS     = tsf_pkg::DEF_COLS,
  parameter int TAG_BITS = tsf_pkg::DEF_TAG_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tsf_pkg::tsf_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tsf_pkg::tsf_out_t out_data
);

  import tsf_pkg::*;

  // sizes derived from the slot grid
  localparam int NSLOTS = ROWS * COLS;
  localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int CW     = $clog2(NSLOTS + 1);
  localparam int CMPW   = (CW > CNT_W) ? CW : CNT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                act_r, act_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                status_r, status_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic [AW-1:0]       p_idx_r, p_idx_nxt;
  logic [CW-1:0]       chg_r, chg_nxt;
  logic [CW-1:0]       free_r, free_nxt;
  logic                out_vld_r, out_vld_nxt;
  tsf_out_t            out_q_r, out_q_nxt;

  logic                in_acc;
  logic                out_load;
  logic [TAG_BITS-1:0] in_tag;
  logic                rd_en;
  logic [TAG_BITS-1:0] rd_data;
  logic                wr_en;
  logic [TAG_BITS-1:0] wr_data;
  logic                hit;
  logic [CW-1:0]       free_new;

  // only the low TAG_BITS bits of the tag take part
  assign in_tag = TAG_BITS'(in_data.tag);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  // a result word can be loaded once the output register is free or draining
  assign out_load = (state_r == S_DONE) && (!out_vld_r || !out_stall);

  assign rd_en = (state_r == S_SCAN);

  // slot store, each slot read in the cycle before its write back
  tsf_slot_mem #(
    .DEPTH (NSLOTS),
    .AW    (AW),
    .DW    (TAG_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (p_idx_r),
    .wr_data (wr_data)
  );

  // modify stage: decide whether the slot just read gets written
  always_comb begin
    hit = 1'b0;
    if (act_r == ACT_FILL) begin
      // empty slot, and fewer slots written so far than asked for
      hit = (rd_data == '0) && (CMPW'(chg_r) < CMPW'(cnt_r));
    end else begin
      // freeing the empty marker touches nothing
      hit = (tag_r != '0) && (rd_data == tag_r);
    end
    wr_en   = p_vld_r && hit;
    wr_data = (act_r == ACT_FILL) ? tag_r : '0;
  end

  // free count after the request; a rejected fill or a fill with the empty marker leaves it alone
  always_comb begin
    free_new = free_r;
    if (status_r == ST_DONE) begin
      if (act_r == ACT_FREE) begin
        free_new = free_r + chg_r;
      end else if (tag_r != '0) begin
        free_new = free_r - chg_r;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    tag_nxt     = tag_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    rd_idx_nxt  = rd_idx_r;
    p_vld_nxt   = 1'b0;
    p_idx_nxt   = p_idx_r;
    chg_nxt     = chg_r;
    free_nxt    = free_r;
    out_vld_nxt = out_vld_r;
    out_q_nxt   = out_q_r;

    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    if (wr_en) begin
      chg_nxt = chg_r + CW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt    = in_data.action;
          tag_nxt    = in_tag;
          cnt_nxt    = in_data.count;
          chg_nxt    = '0;
          rd_idx_nxt = '0;
          if ((in_data.action == ACT_FILL) &&
              (CMPW'(in_data.count) > CMPW'(free_r))) begin
            // not enough room: skip the scan, nothing is written
            status_nxt = ST_NO_SPACE;
            state_nxt  = S_DONE;
          end else begin
            status_nxt = ST_DONE;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        p_vld_nxt = 1'b1;
        p_idx_nxt = rd_idx_r;
        if (rd_idx_r == AW'(NSLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end
      S_DRAIN: begin
        // last slot gets written back in this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          free_nxt                = free_new;
          out_vld_nxt             = 1'b1;
          out_q_nxt.status        = status_r;
          out_q_nxt.free_slots    = CNT_W'(free_new);
          out_q_nxt.slots_changed = CNT_W'(chg_r);
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      p_vld_r   <= 1'b0;
      free_r    <= CW'(NSLOTS);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= p_vld_nxt;
      free_r    <= free_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    tag_r    <= tag_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    rd_idx_r <= rd_idx_nxt;
    p_idx_r  <= p_idx_nxt;
    chg_r    <= chg_nxt;
    out_q_r  <= out_q_nxt;
  end

endmodule
